// ===== design/assert_macros.svh =====
// Assertion macros shared by the character LCD writer modules.
// Each macro takes a label, an antecedent and a consequent, and is
// clocked on clk with rst disabling the check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLNW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("clnw assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CLNW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("clnw assertion failed");

`endif

// ===== design/clnw_pkg.sv =====
package clnw_pkg;

  // Request codes.
  localparam logic [1:0] CMD_INSTR = 2'd0;
  localparam logic [1:0] CMD_DATA  = 2'd1;
  localparam logic [1:0] CMD_INIT  = 2'd2;

  // Field widths.
  localparam int unsigned PHASE_HOLD_W = 8;
  localparam int unsigned TICKS_W      = 20;
  localparam int unsigned NIBBLE_W     = 4;
  localparam int unsigned BYTE_W       = 8;

  // Phase sequencing: three enable phases per nibble, two nibbles per byte.
  localparam int unsigned PHASES_PER_BYTE = 6;
  localparam int unsigned PHASE_W         = $clog2(PHASES_PER_BYTE);
  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(PHASES_PER_BYTE - 1);
  localparam logic [PHASE_W-1:0] PHASE_HI_EN = PHASE_W'(1);
  localparam logic [PHASE_W-1:0] PHASE_LO_EN = PHASE_W'(4);
  localparam logic [PHASE_W-1:0] PHASE_LO_FIRST = PHASE_W'(3);

  // Power-up sequence.
  localparam int unsigned INIT_BYTES = 8;
  localparam int unsigned IDX_W      = $clog2(INIT_BYTES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(INIT_BYTES - 1);

  // Register map: index is paddr[3:2].
  localparam int unsigned PADDR_W = 4;
  localparam logic [1:0] REG_PHASE_HOLD = 2'd0;
  localparam logic [1:0] REG_SETTLE     = 2'd1;
  localparam logic [1:0] REG_STARTUP    = 2'd2;

  localparam logic [PHASE_HOLD_W-1:0] PHASE_HOLD_RST = PHASE_HOLD_W'(1);
  localparam logic [TICKS_W-1:0]      SETTLE_RST     = TICKS_W'(20000);
  localparam logic [TICKS_W-1:0]      STARTUP_RST    = TICKS_W'(60000);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_START = 3'b010,
    S_BYTES = 3'b100
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic emit_start;
    logic emit_phase;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic slot_free;
    logic last_phase;
    logic last_byte;
  } dp_status_t;

  // Effective hold times, already forced to at least one tick.
  typedef struct packed {
    logic [TICKS_W-1:0] phase_hold;
    logic [TICKS_W-1:0] settle;
    logic [TICKS_W-1:0] startup;
  } hold_cfg_t;

  function automatic logic [BYTE_W-1:0] init_byte(input logic [IDX_W-1:0] idx);
    logic [BYTE_W-1:0] b;
    unique case (idx)
      3'd0, 3'd1, 3'd2: b = 8'h03;
      3'd3:             b = 8'h02;
      3'd4:             b = 8'h28;
      3'd5:             b = 8'h01;
      3'd6:             b = 8'h06;
      3'd7:             b = 8'h0f;
      default:          b = 8'h0f;
    endcase
    return b;
  endfunction

endpackage

// ===== design/clnw_cfg.sv =====
module clnw_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [clnw_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output clnw_pkg::hold_cfg_t             hold_cfg
);

  logic [clnw_pkg::PHASE_HOLD_W-1:0] phase_hold_ticks;
  logic [clnw_pkg::TICKS_W-1:0]      settle_ticks;
  logic [clnw_pkg::TICKS_W-1:0]      startup_ticks;
  logic                              wr_en;
  logic [1:0]                        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_hold_ticks <= clnw_pkg::PHASE_HOLD_RST;
      settle_ticks     <= clnw_pkg::SETTLE_RST;
      startup_ticks    <= clnw_pkg::STARTUP_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        clnw_pkg::REG_PHASE_HOLD: phase_hold_ticks <= pwdata[clnw_pkg::PHASE_HOLD_W-1:0];
        clnw_pkg::REG_SETTLE:     settle_ticks     <= pwdata[clnw_pkg::TICKS_W-1:0];
        clnw_pkg::REG_STARTUP:    startup_ticks    <= pwdata[clnw_pkg::TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      clnw_pkg::REG_PHASE_HOLD: prdata = 32'(phase_hold_ticks);
      clnw_pkg::REG_SETTLE:     prdata = 32'(settle_ticks);
      clnw_pkg::REG_STARTUP:    prdata = 32'(startup_ticks);
      default:                  prdata = 32'd0;
    endcase
  end

  // A register holding zero is used as one tick.
  always_comb begin
    hold_cfg.phase_hold = (phase_hold_ticks == '0) ? clnw_pkg::TICKS_W'(1)
                                                   : clnw_pkg::TICKS_W'(phase_hold_ticks);
    hold_cfg.settle     = (settle_ticks == '0) ? clnw_pkg::TICKS_W'(1) : settle_ticks;
    hold_cfg.startup    = (startup_ticks == '0) ? clnw_pkg::TICKS_W'(1) : startup_ticks;
  end

endmodule

// ===== design/clnw_dpath.sv =====
`include "assert_macros.svh"

module clnw_dpath (
  input  logic                             clk,
  input  logic                             rst,
  input  clnw_pkg::dp_cmd_t                cmd,
  output clnw_pkg::dp_status_t             status,
  input  logic [1:0]                       command,
  input  logic [clnw_pkg::BYTE_W-1:0]      byte_value,
  input  clnw_pkg::hold_cfg_t              hold_cfg,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             reg_select,
  output logic                             read_write,
  output logic                             enable,
  output logic [clnw_pkg::NIBBLE_W-1:0]    nibble,
  output logic [clnw_pkg::TICKS_W-1:0]     hold_ticks,
  output logic                             last
);

  logic                            init_mode;
  logic                            rs;
  logic [clnw_pkg::BYTE_W-1:0]     byte_reg;
  logic [clnw_pkg::PHASE_W-1:0]    phase;
  logic [clnw_pkg::IDX_W-1:0]      byte_idx;
  logic [clnw_pkg::BYTE_W-1:0]     cur_byte;
  logic [clnw_pkg::NIBBLE_W-1:0]   cur_nibble;
  logic                            cur_enable;

  assign cur_byte   = init_mode ? clnw_pkg::init_byte(byte_idx) : byte_reg;
  assign cur_nibble = (phase < clnw_pkg::PHASE_LO_FIRST)
                      ? cur_byte[clnw_pkg::BYTE_W-1:clnw_pkg::NIBBLE_W]
                      : cur_byte[clnw_pkg::NIBBLE_W-1:0];
  assign cur_enable = (phase == clnw_pkg::PHASE_HI_EN) || (phase == clnw_pkg::PHASE_LO_EN);

  assign status.slot_free  = !out_valid || out_ready;
  assign status.last_phase = (phase == clnw_pkg::PHASE_LAST);
  assign status.last_byte  = !init_mode || (byte_idx == clnw_pkg::IDX_LAST);

  assign read_write = 1'b0;

  // Request registers and phase counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= '0;
      byte_idx <= '0;
    end else if (cmd.load) begin
      phase    <= '0;
      byte_idx <= '0;
    end else if (cmd.emit_phase) begin
      if (status.last_phase) begin
        phase    <= '0;
        byte_idx <= byte_idx + clnw_pkg::IDX_W'(1);
      end else begin
        phase <= phase + clnw_pkg::PHASE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      init_mode <= (command == clnw_pkg::CMD_INIT);
      rs        <= (command == clnw_pkg::CMD_DATA);
      byte_reg  <= byte_value;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_start || cmd.emit_phase) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_start) begin
      reg_select <= 1'b0;
      enable     <= 1'b0;
      nibble     <= '0;
      hold_ticks <= hold_cfg.startup;
      last       <= 1'b0;
    end else if (cmd.emit_phase) begin
      reg_select <= rs;
      enable     <= cur_enable;
      nibble     <= cur_nibble;
      hold_ticks <= status.last_phase ? hold_cfg.settle : hold_cfg.phase_hold;
      last       <= status.last_phase && status.last_byte;
    end
  end

  `CLNW_ASSERT_NOW(a_emit_into_free_slot, cmd.emit_start || cmd.emit_phase, status.slot_free)
  `CLNW_ASSERT_NEXT(a_final_phase_marked,
                    cmd.emit_phase && status.last_phase && status.last_byte,
                    out_valid && last)

endmodule

// ===== design/clnw_ctrl.sv =====
`include "assert_macros.svh"

module clnw_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            command,
  input  clnw_pkg::dp_status_t  status,
  output clnw_pkg::dp_cmd_t     cmd
);

  clnw_pkg::state_t state;
  clnw_pkg::state_t state_next;
  logic             accept;

  assign in_ready = (state == clnw_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next     = state;
    cmd.load       = 1'b0;
    cmd.emit_start = 1'b0;
    cmd.emit_phase = 1'b0;
    unique case (state)
      clnw_pkg::S_IDLE: begin
        if (accept) begin
          case (command) inside
            clnw_pkg::CMD_INSTR, clnw_pkg::CMD_DATA: begin
              cmd.load   = 1'b1;
              state_next = clnw_pkg::S_BYTES;
            end
            clnw_pkg::CMD_INIT: begin
              cmd.load   = 1'b1;
              state_next = clnw_pkg::S_START;
            end
            default: ;
          endcase
        end
      end
      clnw_pkg::S_START: begin
        if (status.slot_free) begin
          cmd.emit_start = 1'b1;
          state_next     = clnw_pkg::S_BYTES;
        end
      end
      clnw_pkg::S_BYTES: begin
        if (status.slot_free) begin
          cmd.emit_phase = 1'b1;
          if (status.last_phase && status.last_byte) begin
            state_next = clnw_pkg::S_IDLE;
          end
        end
      end
      default: state_next = clnw_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= clnw_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `CLNW_ASSERT_NEXT(a_init_goes_to_start,
                    accept && (command == clnw_pkg::CMD_INIT),
                    state == clnw_pkg::S_START)
  `CLNW_ASSERT_NEXT(a_final_phase_ends_request,
                    cmd.emit_phase && status.last_phase && status.last_byte,
                    in_ready)

endmodule

// ===== design/char_lcd_nibble_writer_top.sv =====
// Channel   Handshake              Payload
// in        in_valid / in_ready    command, byte_value
// out       out_valid / out_ready  reg_select, read_write, enable, nibble,
//                                  hold_ticks, last
// cfg       psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
// A request is taken while the block is idle, then one pin-phase result is
// loaded into the output register per cycle while out_ready is high: a byte
// write gives 6 results and the initialisation gives 49.
// The rate is set by the single output register and the phase counter.
// Reset (rst, synchronous) restores the hold registers to 1, 20000 and 60000.
// A stall on out_ready freezes the sequence; the next request is taken as
// soon as the final result of the current one sits in the output register.

module char_lcd_nibble_writer_top (
  input  logic                             clk,
  input  logic                             rst,
  // Request channel.
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       command,
  input  logic [clnw_pkg::BYTE_W-1:0]      byte_value,
  // Pin-phase result channel.
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             reg_select,
  output logic                             read_write,
  output logic                             enable,
  output logic [clnw_pkg::NIBBLE_W-1:0]    nibble,
  output logic [clnw_pkg::TICKS_W-1:0]     hold_ticks,
  output logic                             last,
  // Register port.
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [clnw_pkg::PADDR_W-1:0]     paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  // The datapath is steered by the controller through a small command
  // bundle and reports back whether the output slot is free and whether
  // the current phase closes the request.
  clnw_pkg::dp_cmd_t    cmd;
  clnw_pkg::dp_status_t status;
  clnw_pkg::hold_cfg_t  hold_cfg;

  // Hold-time registers; zero values are presented to the datapath as one.
  clnw_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .hold_cfg (hold_cfg)
  );

  // The controller only accepts a request while idle; an unknown command
  // code is taken and dropped without producing any transfer.
  clnw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the request, walks the six phases of each byte and
  // the eight power-up bytes, and owns the output register.
  clnw_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .command    (command),
    .byte_value (byte_value),
    .hold_cfg   (hold_cfg),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .reg_select (reg_select),
    .read_write (read_write),
    .enable     (enable),
    .nibble     (nibble),
    .hold_ticks (hold_ticks),
    .last       (last)
  );

endmodule
